### src/staged_rail_power_sequencer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the staged rail power sequencer.
// Defining ASSERT_OFF removes every check from the build.
// ----------------------------------------------------------------------------
`ifndef STAGED_RAIL_POWER_SEQUENCER_MACROS_SVH
`define STAGED_RAIL_POWER_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is held.
`define RPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held.
`define RPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### src/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Types, codes and stage tables shared by the rail power sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

    localparam int DEVICE_COUNT_DEF = 2;
    localparam int DEVICE_MAX       = 4;

    localparam int CMD_W      = 2;
    localparam int GOOD_W     = 11;
    localparam int EN_W       = 12;
    localparam int RST_W      = 2;
    localparam int FLAG_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 16;
    localparam int RETRY_W    = 4;
    localparam int STAGE_W    = 3;
    localparam int RAIL_IDX_W = 2;
    localparam int RAIL_W     = 4;

    typedef logic [CMD_W-1:0]      t_cmd;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [STAGE_W-1:0]    t_stage;
    typedef logic [RAIL_IDX_W-1:0] t_rail_idx;
    typedef logic [RAIL_W-1:0]     t_rail;
    typedef logic [EN_W-1:0]       t_enables;

    localparam t_cmd CMD_TICK = 2'd0;
    localparam t_cmd CMD_ON   = 2'd1;
    localparam t_cmd CMD_OFF  = 2'd2;

    localparam t_cfg_idx CFG_CHECK_DELAY     = 2'd0;
    localparam t_cfg_idx CFG_RETRY_LIMIT     = 2'd1;
    localparam t_cfg_idx CFG_DISCHARGE_DELAY = 2'd2;
    localparam t_cfg_idx CFG_RESET_DELAY     = 2'd3;

    localparam logic [DELAY_W-1:0] CHECK_DELAY_RST     = 16'd100;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST     = 4'd5;
    localparam logic [DELAY_W-1:0] DISCHARGE_DELAY_RST = 16'd100;
    localparam logic [DELAY_W-1:0] RESET_DELAY_RST     = 16'd100;

    // Stages with extra duties.
    localparam t_stage STG_OFF_RESET_DROP = 3'd3;
    localparam t_stage STG_OFF_DISCHARGE  = 3'd4;
    localparam t_stage STG_ON_VTT         = 3'd6;
    localparam t_stage STAGE_END          = 3'd7;

    localparam logic [RST_W-1:0] RST_RELEASED = 2'b11;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [GOOD_W-1:0] good_dev0;
        logic [GOOD_W-1:0] good_dev1;
    } t_item;

    typedef struct packed {
        logic [DELAY_W-1:0] check_delay;
        logic [RETRY_W-1:0] retry_limit;
        logic [DELAY_W-1:0] discharge_delay;
        logic [DELAY_W-1:0] reset_delay;
    } t_cfg;

    typedef struct packed {
        logic [EN_W-1:0]   enables_dev0;
        logic [EN_W-1:0]   enables_dev1;
        logic [RST_W-1:0]  resets_dev0;
        logic [RST_W-1:0]  resets_dev1;
        logic              card_ok;
        logic [FLAG_W-1:0] devices_on;
        logic              busy_res;
        logic [FLAG_W-1:0] failed;
    } t_result;

    // Enables set by each power-on stage.
    function automatic t_enables on_mask(input t_stage s);
        case (s)
            3'd0:    on_mask = 12'h02A;
            3'd1:    on_mask = 12'h001;
            3'd2:    on_mask = 12'h004;
            3'd3:    on_mask = 12'h010;
            3'd4:    on_mask = 12'h0C0;
            3'd5:    on_mask = 12'h300;
            3'd6:    on_mask = 12'hC00;
            default: on_mask = 12'h000;
        endcase
    endfunction

    // Enables cleared by each power-off stage.
    function automatic t_enables off_mask(input t_stage s);
        case (s)
            3'd0:    off_mask = 12'hC00;
            3'd1:    off_mask = 12'h300;
            3'd2:    off_mask = 12'h0C0;
            3'd3:    off_mask = 12'h034;
            3'd4:    off_mask = 12'h008;
            3'd5:    off_mask = 12'h002;
            3'd6:    off_mask = 12'h001;
            default: off_mask = 12'h000;
        endcase
    endfunction

    function automatic t_rail_idx on_cnt(input t_stage s);
        case (s)
            3'd0:    on_cnt = 2'd3;
            3'd1:    on_cnt = 2'd0;
            3'd2:    on_cnt = 2'd1;
            3'd3:    on_cnt = 2'd1;
            3'd4:    on_cnt = 2'd2;
            3'd5:    on_cnt = 2'd2;
            3'd6:    on_cnt = 2'd2;
            default: on_cnt = 2'd0;
        endcase
    endfunction

    function automatic t_rail_idx off_cnt(input t_stage s);
        case (s)
            3'd0:    off_cnt = 2'd2;
            3'd1:    off_cnt = 2'd2;
            3'd2:    off_cnt = 2'd2;
            3'd3:    off_cnt = 2'd3;
            3'd4:    off_cnt = 2'd1;
            3'd5:    off_cnt = 2'd1;
            default: off_cnt = 2'd0;
        endcase
    endfunction

    // Power-good bit checked for the given rail slot of a power-on stage.
    function automatic t_rail on_rail(input t_stage s, input t_rail_idx r);
        case (s)
            3'd0:    on_rail = (r == 2'd0) ? 4'd0 : ((r == 2'd1) ? 4'd2 : 4'd4);
            3'd2:    on_rail = 4'd1;
            3'd3:    on_rail = 4'd3;
            3'd4:    on_rail = (r == 2'd0) ? 4'd5 : 4'd6;
            3'd5:    on_rail = (r == 2'd0) ? 4'd7 : 4'd8;
            3'd6:    on_rail = (r == 2'd0) ? 4'd9 : 4'd10;
            default: on_rail = 4'd0;
        endcase
    endfunction

    // Power-good bit checked for the given rail slot of a power-off stage.
    function automatic t_rail off_rail(input t_stage s, input t_rail_idx r);
        case (s)
            3'd0:    off_rail = (r == 2'd0) ? 4'd9 : 4'd10;
            3'd1:    off_rail = (r == 2'd0) ? 4'd7 : 4'd8;
            3'd2:    off_rail = (r == 2'd0) ? 4'd5 : 4'd6;
            3'd3:    off_rail = (r == 2'd0) ? 4'd1 : ((r == 2'd1) ? 4'd3 : 4'd4);
            3'd4:    off_rail = 4'd2;
            default: off_rail = 4'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

### src/rps_item_if.sv
// ----------------------------------------------------------------------------
// rps_item_if
// Valid/ready channel that carries one command and the power-good samples of two devices.
// ----------------------------------------------------------------------------
`default_nettype none

interface rps_item_if import rps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [GOOD_W-1:0] good_dev0;
    logic [GOOD_W-1:0] good_dev1;

    modport source (output valid, output cmd, output good_dev0, output good_dev1,
                    input ready);
    modport sink   (input valid, input cmd, input good_dev0, input good_dev1,
                    output ready);
endinterface

`default_nettype wire

### src/rps_result_if.sv
// ----------------------------------------------------------------------------
// rps_result_if
// Valid/ready channel that carries the sequencer outputs after each item.
// ----------------------------------------------------------------------------
`default_nettype none

interface rps_result_if import rps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [EN_W-1:0]   enables_dev0;
    logic [EN_W-1:0]   enables_dev1;
    logic [RST_W-1:0]  resets_dev0;
    logic [RST_W-1:0]  resets_dev1;
    logic              card_ok;
    logic [FLAG_W-1:0] devices_on;
    logic              busy_res;
    logic [FLAG_W-1:0] failed;

    modport source (output valid, output enables_dev0, output enables_dev1,
                    output resets_dev0, output resets_dev1, output card_ok,
                    output devices_on, output busy_res, output failed,
                    input ready);
    modport sink   (input valid, input enables_dev0, input enables_dev1,
                    input resets_dev0, input resets_dev1, input card_ok,
                    input devices_on, input busy_res, input failed,
                    output ready);
endinterface

`default_nettype wire

### src/rps_cfg_regs.sv
// ----------------------------------------------------------------------------
// rps_cfg_regs
// Timing and retry registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_cfg_regs import rps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  t_cfg_idx              i_idx,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_delay     <= CHECK_DELAY_RST;
            r_cfg.retry_limit     <= RETRY_LIMIT_RST;
            r_cfg.discharge_delay <= DISCHARGE_DELAY_RST;
            r_cfg.reset_delay     <= RESET_DELAY_RST;
        end else if (i_we) begin
            case (i_idx)
                CFG_CHECK_DELAY:     r_cfg.check_delay     <= i_data[DELAY_W-1:0];
                CFG_RETRY_LIMIT:     r_cfg.retry_limit     <= i_data[RETRY_W-1:0];
                CFG_DISCHARGE_DELAY: r_cfg.discharge_delay <= i_data[DELAY_W-1:0];
                CFG_RESET_DELAY:     r_cfg.reset_delay     <= i_data[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### src/rps_seq_core.sv
// ----------------------------------------------------------------------------
// rps_seq_core
// Sequencer state and the single-pass next-state logic for one item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "staged_rail_power_sequencer_macros.svh"

module rps_seq_core import rps_pkg::*; #(
    parameter int DEVICE_COUNT = DEVICE_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_next
);

    localparam int DEV_W        = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
    localparam int DEV_HI       = (DEVICE_COUNT > 1) ? 1 : 0;
    localparam int ENTRY_PASSES = 2;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ON   = 2'd1;
    localparam logic [1:0] PH_OFF  = 2'd2;

    localparam logic [1:0] SUB_DISCHARGE = 2'd0;
    localparam logic [1:0] SUB_SETTLE    = 2'd1;
    localparam logic [1:0] SUB_CHECK     = 2'd2;

    logic [1:0]         r_phase,   n_phase;
    logic [DEV_W-1:0]   r_dev,     n_dev;
    t_stage             r_stage,   n_stage;
    t_rail_idx          r_rail,    n_rail;
    logic [RETRY_W-1:0] r_attempt, n_attempt;
    logic [DELAY_W-1:0] r_wait,    n_wait;
    logic [1:0]         r_sub,     n_sub;
    t_enables           r_en      [DEVICE_COUNT];
    t_enables           n_en      [DEVICE_COUNT];
    logic [RST_W-1:0]   r_rst     [DEVICE_COUNT];
    logic [RST_W-1:0]   n_rst     [DEVICE_COUNT];
    logic [DELAY_W-1:0] r_tmr_cnt [DEVICE_COUNT];
    logic [DELAY_W-1:0] n_tmr_cnt [DEVICE_COUNT];
    logic [DEVICE_COUNT-1:0] r_tmr_act, n_tmr_act;
    logic [DEVICE_COUNT-1:0] r_on,      n_on;
    logic [DEVICE_COUNT-1:0] r_fail,    n_fail;
    logic               r_card,    n_card;

    logic [GOOD_W-1:0]  gd [DEVICE_COUNT];
    logic [DELAY_W-1:0] eff_chk;
    logic [RETRY_W-1:0] eff_rty;
    logic [DEVICE_MAX-1:0] on_ext;
    logic [DEVICE_MAX-1:0] fail_ext;

    // A zero check delay or retry limit behaves as one.
    assign eff_chk = (i_cfg.check_delay == '0) ? DELAY_W'(1) : i_cfg.check_delay;
    assign eff_rty = (i_cfg.retry_limit == '0) ? RETRY_W'(1) : i_cfg.retry_limit;

    // Only the first two devices have power-good inputs.
    always_comb begin
        for (int d = 0; d < DEVICE_COUNT; d++) begin
            gd[d] = (d == 0) ? i_item.good_dev0 :
                    ((d == 1) ? i_item.good_dev1 : '0);
        end
    end

    always_comb begin
        logic               pend;
        logic               fail;
        logic               ok;
        logic               wait_done;
        logic [DELAY_W-1:0] thr;
        logic [DELAY_W-1:0] tmr_dec;
        t_rail_idx          cnt;
        t_rail              rail;
        logic               good_bit;

        n_phase   = r_phase;
        n_dev     = r_dev;
        n_stage   = r_stage;
        n_rail    = r_rail;
        n_attempt = r_attempt;
        n_wait    = r_wait;
        n_sub     = r_sub;
        n_en      = r_en;
        n_rst     = r_rst;
        n_tmr_cnt = r_tmr_cnt;
        n_tmr_act = r_tmr_act;
        n_on      = r_on;
        n_fail    = r_fail;
        n_card    = r_card;

        pend     = 1'b0;
        fail     = 1'b0;
        ok       = 1'b0;
        tmr_dec  = '0;
        cnt      = '0;
        rail     = '0;
        good_bit = 1'b0;
        thr       = (r_sub == SUB_DISCHARGE) ? i_cfg.discharge_delay : eff_chk;
        wait_done = ({1'b0, r_wait} + 17'd1) >= {1'b0, thr};

        case (i_item.cmd)
            CMD_TICK: begin
                // Release timers count before the sequencer moves.
                for (int d = 0; d < DEVICE_COUNT; d++) begin
                    if (r_tmr_act[d]) begin
                        tmr_dec = r_tmr_cnt[d] - DELAY_W'(1);
                        if (tmr_dec == '0) begin
                            n_rst[d]     = RST_RELEASED;
                            n_tmr_act[d] = 1'b0;
                            n_tmr_cnt[d] = '0;
                        end else begin
                            n_tmr_cnt[d] = tmr_dec;
                        end
                    end
                end
                if (r_phase != PH_IDLE) begin
                    if (r_stage == STAGE_END) begin
                        pend = 1'b1;
                    end else if (r_sub == SUB_DISCHARGE) begin
                        if (wait_done) begin
                            n_en[r_dev] = n_en[r_dev] & ~off_mask(r_stage);
                            if (r_stage == STG_OFF_RESET_DROP) begin
                                n_rst[r_dev]     = '0;
                                n_tmr_act[r_dev] = 1'b0;
                                n_tmr_cnt[r_dev] = '0;
                            end
                            n_sub  = SUB_SETTLE;
                            n_wait = '0;
                        end else begin
                            n_wait = r_wait + DELAY_W'(1);
                        end
                    end else if (r_sub == SUB_SETTLE) begin
                        if (wait_done) begin
                            n_wait    = '0;
                            n_sub     = SUB_CHECK;
                            n_rail    = '0;
                            n_attempt = '0;
                            if (off_cnt(r_stage) == '0) begin
                                n_stage = r_stage + STAGE_W'(1);
                                pend    = 1'b1;
                            end
                        end else begin
                            n_wait = r_wait + DELAY_W'(1);
                        end
                    end else begin
                        if (!wait_done) begin
                            n_wait = r_wait + DELAY_W'(1);
                        end else begin
                            n_wait = '0;
                            cnt = (r_phase == PH_ON) ? on_cnt(r_stage) : off_cnt(r_stage);
                            if (r_rail >= cnt) begin
                                n_stage = r_stage + STAGE_W'(1);
                                pend    = 1'b1;
                            end else begin
                                rail = (r_phase == PH_ON) ? on_rail(r_stage, r_rail) :
                                                            off_rail(r_stage, r_rail);
                                good_bit = gd[r_dev][rail];
                                // Power on waits for good high, power off for good low.
                                if (good_bit == (r_phase == PH_ON)) begin
                                    n_rail    = r_rail + RAIL_IDX_W'(1);
                                    n_attempt = '0;
                                    if (n_rail >= cnt) begin
                                        n_stage = r_stage + STAGE_W'(1);
                                        pend    = 1'b1;
                                    end
                                end else begin
                                    n_attempt = r_attempt + RETRY_W'(1);
                                    if (n_attempt >= eff_rty) begin
                                        fail = 1'b1;
                                        pend = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            CMD_ON: begin
                if (r_phase == PH_IDLE && !r_card) begin
                    n_fail  = '0;
                    n_dev   = '0;
                    n_stage = '0;
                    n_phase = PH_ON;
                    pend    = 1'b1;
                end
            end
            CMD_OFF: begin
                if (r_phase == PH_IDLE && r_card) begin
                    n_card  = 1'b0;
                    n_fail  = '0;
                    n_dev   = '0;
                    n_stage = '0;
                    n_phase = PH_OFF;
                    pend    = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Stage entry. Two passes cover the longest chain: closing a device and
        // entering the first stage of the next, or passing the clock stage.
        for (int k = 0; k < ENTRY_PASSES; k++) begin
            if (pend) begin
                if (n_phase == PH_IDLE) begin
                    pend = 1'b0;
                end else if (n_stage == STAGE_END || fail) begin
                    ok   = !fail;
                    fail = 1'b0;
                    n_on[n_dev] = (n_phase == PH_ON) ? ok : !ok;
                    if (!ok) begin
                        n_fail[n_dev] = 1'b1;
                    end
                    n_stage = '0;
                    if (n_dev == DEV_W'(DEVICE_COUNT - 1)) begin
                        if (n_phase == PH_ON && n_on == '1) begin
                            n_card = 1'b1;
                        end
                        n_phase = PH_IDLE;
                        n_dev   = '0;
                    end else begin
                        n_dev = n_dev + DEV_W'(1);
                    end
                end else begin
                    n_wait    = '0;
                    n_rail    = '0;
                    n_attempt = '0;
                    if (n_phase == PH_ON) begin
                        n_en[n_dev] = n_en[n_dev] | on_mask(n_stage);
                        if (n_stage == STG_ON_VTT) begin
                            if (i_cfg.reset_delay == '0) begin
                                n_rst[n_dev]     = RST_RELEASED;
                                n_tmr_act[n_dev] = 1'b0;
                                n_tmr_cnt[n_dev] = '0;
                            end else begin
                                n_tmr_act[n_dev] = 1'b1;
                                n_tmr_cnt[n_dev] = i_cfg.reset_delay;
                            end
                        end
                        n_sub = SUB_CHECK;
                        if (on_cnt(n_stage) != '0) begin
                            pend = 1'b0;
                        end else begin
                            n_stage = n_stage + STAGE_W'(1);
                        end
                    end else begin
                        if (n_stage == STG_OFF_DISCHARGE && i_cfg.discharge_delay != '0) begin
                            n_sub = SUB_DISCHARGE;
                        end else begin
                            n_en[n_dev] = n_en[n_dev] & ~off_mask(n_stage);
                            if (n_stage == STG_OFF_RESET_DROP) begin
                                n_rst[n_dev]     = '0;
                                n_tmr_act[n_dev] = 1'b0;
                                n_tmr_cnt[n_dev] = '0;
                            end
                            n_sub = SUB_SETTLE;
                        end
                        pend = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_dev     <= '0;
            r_stage   <= '0;
            r_rail    <= '0;
            r_attempt <= '0;
            r_wait    <= '0;
            r_sub     <= SUB_DISCHARGE;
            for (int d = 0; d < DEVICE_COUNT; d++) begin
                r_en[d]      <= '0;
                r_rst[d]     <= '0;
                r_tmr_cnt[d] <= '0;
            end
            r_tmr_act <= '0;
            r_on      <= '0;
            r_fail    <= '0;
            r_card    <= 1'b0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_dev     <= n_dev;
            r_stage   <= n_stage;
            r_rail    <= n_rail;
            r_attempt <= n_attempt;
            r_wait    <= n_wait;
            r_sub     <= n_sub;
            r_en      <= n_en;
            r_rst     <= n_rst;
            r_tmr_cnt <= n_tmr_cnt;
            r_tmr_act <= n_tmr_act;
            r_on      <= n_on;
            r_fail    <= n_fail;
            r_card    <= n_card;
        end
    end

    assign on_ext   = DEVICE_MAX'(n_on);
    assign fail_ext = DEVICE_MAX'(n_fail);

    assign o_next.enables_dev0 = n_en[0];
    assign o_next.enables_dev1 = (DEVICE_COUNT > 1) ? n_en[DEV_HI] : '0;
    assign o_next.resets_dev0  = n_rst[0];
    assign o_next.resets_dev1  = (DEVICE_COUNT > 1) ? n_rst[DEV_HI] : '0;
    assign o_next.card_ok      = n_card;
    assign o_next.devices_on   = on_ext[FLAG_W-1:0];
    assign o_next.busy_res     = (n_phase != PH_IDLE);
    assign o_next.failed       = fail_ext[FLAG_W-1:0];

    `RPS_ASSERT_IMPL(a_idle_home, i_clk, i_rst_n, r_phase == PH_IDLE, r_dev == '0 && r_stage == '0, "idle sequencer left away from the first device and stage")
    `RPS_ASSERT_IMPL(a_card_idle, i_clk, i_rst_n, r_card, r_phase == PH_IDLE, "card ok high while a sequence runs")
    `RPS_ASSERT_IMPL(a_timer_live, i_clk, i_rst_n, r_tmr_act[0], r_tmr_cnt[0] != '0, "active release timer holds zero")
    `RPS_ASSERT_IMPL(a_rail_bound, i_clk, i_rst_n, r_phase != PH_IDLE, r_rail != '1, "rail slot ran past the last rail of a stage")
    `RPS_ASSERT_NEXT(a_on_start, i_clk, i_rst_n, i_step && i_item.cmd == CMD_ON && r_phase == PH_IDLE && !r_card, r_phase == PH_ON && r_fail == '0, "power on request did not start a clean sequence")

endmodule

`default_nettype wire

### src/staged_rail_power_sequencer.sv
// ----------------------------------------------------------------------------
// staged_rail_power_sequencer: two-device staged rail power sequencer.
// Path: an item waits in the input register; its result is registered when it advances.
// Throughput: one item per cycle while the result is taken, set by the single-pass sequencer update.
// Stalls: the input stalls only while both the input and result registers hold.
// Reset: synchronous active low; clears all sequencer state, config to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module staged_rail_power_sequencer import rps_pkg::*; #(
    parameter int DEVICE_COUNT = DEVICE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rps_item_if.sink              i_in,
    rps_result_if.source          o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    logic    advance;
    logic    in_xfer;
    t_cfg    cfg;
    t_result next_res;

    // The buffered item moves on whenever the result register is free or drains.
    assign advance   = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in.cmd       <= i_in.cmd;
            r_in.good_dev0 <= i_in.good_dev0;
            r_in.good_dev1 <= i_in.good_dev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= next_res;
        end
    end

    rps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    rps_seq_core #(
        .DEVICE_COUNT (DEVICE_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_next  (next_res)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.enables_dev0 = r_out.enables_dev0;
    assign o_out.enables_dev1 = r_out.enables_dev1;
    assign o_out.resets_dev0  = r_out.resets_dev0;
    assign o_out.resets_dev1  = r_out.resets_dev1;
    assign o_out.card_ok      = r_out.card_ok;
    assign o_out.devices_on   = r_out.devices_on;
    assign o_out.busy_res     = r_out.busy_res;
    assign o_out.failed       = r_out.failed;

endmodule

`default_nettype wire
